FILE: rtl/bsm_pkg.sv
package bsm_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned RadiusW  = 31;
  localparam int unsigned MagW     = 33;  // |c_in - c| can reach 2^32 - 1
  localparam int unsigned MulW     = 34;  // multiplier operand width
  localparam int unsigned ProdW    = 2 * MulW;
  localparam int unsigned SumSqW   = 66;  // three squares of 33-bit values
  localparam int unsigned SqrtOpW  = 70;  // even width, two bits a step
  localparam int unsigned SqrtSteps = SqrtOpW / 2;
  localparam int unsigned RootW    = SqrtSteps;
  localparam int unsigned SqRemW   = 38;
  localparam int unsigned DistW    = 34;
  localparam int unsigned KW       = 35;
  localparam int unsigned DivSteps = 33;  // quotient never exceeds 2^32
  localparam int unsigned DivisorW = DistW + 1;
  localparam int unsigned CntW     = 6;

  localparam logic [RadiusW-1:0] RadiusMax = {RadiusW{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_SQRT,
    ST_DECIDE,
    ST_AX_MUL,
    ST_AX_LOAD,
    ST_DIV,
    ST_AX_DONE,
    ST_WRITE
  } bsm_state_t;

  typedef struct packed {
    logic contained;
    logic kept_inside;
  } bsm_decision_t;

endpackage

FILE: rtl/bsm_in_if.sv
interface bsm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 command;
  logic signed [bsm_pkg::CoordW-1:0]    in_center_x;
  logic signed [bsm_pkg::CoordW-1:0]    in_center_y;
  logic signed [bsm_pkg::CoordW-1:0]    in_center_z;
  logic        [bsm_pkg::RadiusW-1:0]   in_radius;

  modport source (output valid, command, in_center_x, in_center_y, in_center_z, in_radius,
                  input ready);
  modport sink (input valid, command, in_center_x, in_center_y, in_center_z, in_radius,
                output ready);
endinterface

FILE: rtl/bsm_out_if.sv
interface bsm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bsm_pkg::CoordW-1:0]    out_center_x;
  logic signed [bsm_pkg::CoordW-1:0]    out_center_y;
  logic signed [bsm_pkg::CoordW-1:0]    out_center_z;
  logic        [bsm_pkg::RadiusW-1:0]   out_radius;
  logic                                 saturated;

  modport source (output valid, out_center_x, out_center_y, out_center_z, out_radius,
                  saturated, input ready);
  modport sink (input valid, out_center_x, out_center_y, out_center_z, out_radius,
                saturated, output ready);
endinterface

FILE: rtl/bsm_mul.sv
module bsm_mul (
  input  logic                         clk,
  input  logic [bsm_pkg::MulW-1:0]     a,
  input  logic [bsm_pkg::MulW-1:0]     b,
  output logic [bsm_pkg::ProdW-1:0]    p_r
);

  always_ff @(posedge clk) begin
    p_r <= bsm_pkg::ProdW'(a) * bsm_pkg::ProdW'(b);
  end

endmodule

FILE: rtl/bounding_sphere_merge_top.sv
// a fresh take goes straight to the write; when one sphere holds the other, the squares
// of the 3 axes and the 35-step root run first; a full merge then multiplies and divides
// per axis. One word is taken at a time and the block is busy until it is written; a
// single shared multiplier, a two-bit-a-step root unit and a one-bit-a-step divider
// do the work; the output register lets the next word be accepted while a result waits
// reset (synchronous, rst_n low): no sphere held, output empty, sequencer idle
module bounding_sphere_merge_top (
  input  logic     clk,
  input  logic     rst_n,
  bsm_in_if.sink   in_ch,
  bsm_out_if.source out_ch
);

  bsm_pkg::bsm_state_t state_r, state_nxt;

  logic                              hvalid_r;
  logic signed [bsm_pkg::CoordW-1:0] hx_r, hy_r, hz_r;
  logic        [bsm_pkg::RadiusW-1:0] hr_r;
  logic signed [bsm_pkg::CoordW-1:0] ix_r, iy_r, iz_r;
  logic        [bsm_pkg::RadiusW-1:0] ir_r;
  logic signed [bsm_pkg::CoordW-1:0] resx_r, resy_r, resz_r;
  logic        [bsm_pkg::RadiusW-1:0] resr_r;
  logic                              ressat_r;

  logic [1:0]                        axis_r;
  logic [bsm_pkg::CntW-1:0]          cnt_r;
  logic [bsm_pkg::SumSqW-1:0]        acc_r;
  logic [bsm_pkg::SqrtOpW-1:0]       sqop_r;
  logic [bsm_pkg::SqRemW-1:0]        sqrem_r;
  logic [bsm_pkg::RootW-1:0]         root_r;
  logic [bsm_pkg::KW-1:0]            k_r;
  logic [bsm_pkg::DivisorW-1:0]      drem_r;
  logic [bsm_pkg::DivSteps-1:0]      dlo_r;
  logic [bsm_pkg::DivSteps-1:0]      q_r;

  logic                              ovalid_r;
  logic signed [bsm_pkg::CoordW-1:0] ox_r, oy_r, oz_r;
  logic        [bsm_pkg::RadiusW-1:0] or_r;
  logic                              osat_r;

  logic                              in_ready;
  logic                              accept;
  logic                              fresh;
  logic                              write_go;
  logic                              mul_sq;

  // center differences, 33-bit signed
  logic signed [bsm_pkg::MagW-1:0]   dx, dy, dz, sel_diff;
  logic signed [bsm_pkg::CoordW-1:0] sel_held;
  logic        [bsm_pkg::MagW-1:0]   mag;
  logic        [bsm_pkg::MulW-1:0]   mul_a, mul_b;
  logic        [bsm_pkg::ProdW-1:0]  prod;
  logic        [bsm_pkg::SumSqW-1:0] sum_sq;

  logic        [bsm_pkg::SqRemW-1:0] sq_sh, sq_trial;
  logic                              sq_ge;

  logic        [bsm_pkg::DistW-1:0]  cdist;
  logic        [bsm_pkg::KW-1:0]     dist_ir, dist_hr, sum3;
  logic        [bsm_pkg::DistW-1:0]  nr_full;
  bsm_pkg::bsm_decision_t            dec;
  logic        [bsm_pkg::DivisorW-1:0] divisor;
  logic        [bsm_pkg::DivisorW:0] div_sh;
  logic                              div_ge;
  logic        [bsm_pkg::CoordW+1:0] ctr_wide;
  logic        [bsm_pkg::CoordW-1:0] new_ctr;

  assign accept = in_ch.valid && in_ready;
  assign fresh  = !hvalid_r || in_ch.command;

  assign dx = {ix_r[bsm_pkg::CoordW-1], ix_r} - {hx_r[bsm_pkg::CoordW-1], hx_r};
  assign dy = {iy_r[bsm_pkg::CoordW-1], iy_r} - {hy_r[bsm_pkg::CoordW-1], hy_r};
  assign dz = {iz_r[bsm_pkg::CoordW-1], iz_r} - {hz_r[bsm_pkg::CoordW-1], hz_r};

  always_comb begin
    case (axis_r)
      2'd0: begin
        sel_diff = dx;
        sel_held = hx_r;
      end
      2'd1: begin
        sel_diff = dy;
        sel_held = hy_r;
      end
      default: begin
        sel_diff = dz;
        sel_held = hz_r;
      end
    endcase
  end

  assign mag   = sel_diff[bsm_pkg::MagW-1] ? bsm_pkg::MagW'(-sel_diff)
                                           : bsm_pkg::MagW'(sel_diff);
  assign mul_a = bsm_pkg::MulW'(mag);
  assign mul_b = mul_sq ? bsm_pkg::MulW'(mag) : k_r[bsm_pkg::MulW-1:0];

  bsm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  assign sum_sq = acc_r + prod[bsm_pkg::SumSqW-1:0];

  // digit-by-digit root, two operand bits a step
  assign sq_sh    = {sqrem_r[bsm_pkg::SqRemW-3:0], sqop_r[bsm_pkg::SqrtOpW-1 -: 2]};
  assign sq_trial = bsm_pkg::SqRemW'({root_r, 2'b01});
  assign sq_ge    = sq_sh >= sq_trial;

  assign cdist   = root_r[bsm_pkg::DistW-1:0];
  assign dist_ir = bsm_pkg::KW'(cdist) + bsm_pkg::KW'(ir_r);
  assign dist_hr = bsm_pkg::KW'(cdist) + bsm_pkg::KW'(hr_r);
  assign sum3    = dist_ir + bsm_pkg::KW'(hr_r);
  assign nr_full = sum3[bsm_pkg::KW-1:1];
  assign dec.contained   = (dist_ir < bsm_pkg::KW'(hr_r)) || (cdist == '0 && ir_r == hr_r);
  assign dec.kept_inside = dist_hr < bsm_pkg::KW'(ir_r);

  assign divisor = {cdist, 1'b0};
  assign div_sh  = {drem_r, dlo_r[bsm_pkg::DivSteps-1]};
  assign div_ge  = div_sh >= {1'b0, divisor};

  assign ctr_wide = sel_diff[bsm_pkg::MagW-1]
                  ? {{2{sel_held[bsm_pkg::CoordW-1]}}, sel_held} - {1'b0, q_r}
                  : {{2{sel_held[bsm_pkg::CoordW-1]}}, sel_held} + {1'b0, q_r};
  assign new_ctr  = ctr_wide[bsm_pkg::CoordW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bsm_pkg::ST_IDLE: begin
        if (accept) state_nxt = fresh ? bsm_pkg::ST_WRITE : bsm_pkg::ST_SQ_MUL;
      end
      bsm_pkg::ST_SQ_MUL:  state_nxt = bsm_pkg::ST_SQ_ACC;
      bsm_pkg::ST_SQ_ACC: begin
        state_nxt = (axis_r == 2'd2) ? bsm_pkg::ST_SQRT : bsm_pkg::ST_SQ_MUL;
      end
      bsm_pkg::ST_SQRT: begin
        if (cnt_r == bsm_pkg::CntW'(1)) state_nxt = bsm_pkg::ST_DECIDE;
      end
      bsm_pkg::ST_DECIDE: begin
        state_nxt = (dec.contained || dec.kept_inside) ? bsm_pkg::ST_WRITE
                                                       : bsm_pkg::ST_AX_MUL;
      end
      bsm_pkg::ST_AX_MUL:  state_nxt = bsm_pkg::ST_AX_LOAD;
      bsm_pkg::ST_AX_LOAD: state_nxt = bsm_pkg::ST_DIV;
      bsm_pkg::ST_DIV: begin
        if (cnt_r == bsm_pkg::CntW'(1)) state_nxt = bsm_pkg::ST_AX_DONE;
      end
      bsm_pkg::ST_AX_DONE: begin
        state_nxt = (axis_r == 2'd2) ? bsm_pkg::ST_WRITE : bsm_pkg::ST_AX_MUL;
      end
      bsm_pkg::ST_WRITE: begin
        if (write_go) state_nxt = bsm_pkg::ST_IDLE;
      end
      default: state_nxt = bsm_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    write_go = 1'b0;
    mul_sq   = 1'b0;
    case (state_r)
      bsm_pkg::ST_IDLE:   in_ready = 1'b1;
      bsm_pkg::ST_SQ_MUL: mul_sq   = 1'b1;
      bsm_pkg::ST_WRITE:  write_go = !ovalid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bsm_pkg::ST_IDLE;
      hvalid_r <= 1'b0;
      ovalid_r <= 1'b0;
      axis_r   <= '0;
      cnt_r    <= '0;
      hx_r     <= '0;
      hy_r     <= '0;
      hz_r     <= '0;
      hr_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (ovalid_r && out_ch.ready && !write_go) ovalid_r <= 1'b0;
      case (state_r)
        bsm_pkg::ST_IDLE: begin
          axis_r <= '0;
        end
        bsm_pkg::ST_SQ_ACC: begin
          axis_r <= (axis_r == 2'd2) ? 2'd0 : axis_r + 2'd1;
          if (axis_r == 2'd2) cnt_r <= bsm_pkg::CntW'(bsm_pkg::SqrtSteps);
        end
        bsm_pkg::ST_SQRT: cnt_r <= cnt_r - bsm_pkg::CntW'(1);
        bsm_pkg::ST_DECIDE: axis_r <= '0;
        bsm_pkg::ST_AX_LOAD: cnt_r <= bsm_pkg::CntW'(bsm_pkg::DivSteps);
        bsm_pkg::ST_DIV: cnt_r <= cnt_r - bsm_pkg::CntW'(1);
        bsm_pkg::ST_AX_DONE: axis_r <= (axis_r == 2'd2) ? 2'd0 : axis_r + 2'd1;
        bsm_pkg::ST_WRITE: begin
          if (write_go) begin
            hvalid_r <= 1'b1;
            ovalid_r <= 1'b1;
            hx_r     <= resx_r;
            hy_r     <= resy_r;
            hz_r     <= resz_r;
            hr_r     <= resr_r;
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (state_r)
      bsm_pkg::ST_IDLE: begin
        if (accept) begin
          ix_r   <= in_ch.in_center_x;
          iy_r   <= in_ch.in_center_y;
          iz_r   <= in_ch.in_center_z;
          ir_r   <= in_ch.in_radius;
          acc_r  <= '0;
          resx_r <= in_ch.in_center_x;
          resy_r <= in_ch.in_center_y;
          resz_r <= in_ch.in_center_z;
          resr_r <= in_ch.in_radius;
          ressat_r <= 1'b0;
        end
      end
      bsm_pkg::ST_SQ_ACC: begin
        acc_r   <= sum_sq;
        sqop_r  <= bsm_pkg::SqrtOpW'(sum_sq);
        sqrem_r <= '0;
        root_r  <= '0;
      end
      bsm_pkg::ST_SQRT: begin
        sqop_r  <= {sqop_r[bsm_pkg::SqrtOpW-3:0], 2'b00};
        sqrem_r <= sq_ge ? sq_sh - sq_trial : sq_sh;
        root_r  <= {root_r[bsm_pkg::RootW-2:0], sq_ge};
      end
      bsm_pkg::ST_DECIDE: begin
        if (dec.contained) begin
          resx_r <= hx_r;
          resy_r <= hy_r;
          resz_r <= hz_r;
          resr_r <= hr_r;
        end else if (!dec.kept_inside) begin
          // merge: the far surface points span the new sphere
          k_r      <= dist_ir - bsm_pkg::KW'(hr_r);
          ressat_r <= |nr_full[bsm_pkg::DistW-1:bsm_pkg::RadiusW];
          resr_r   <= (|nr_full[bsm_pkg::DistW-1:bsm_pkg::RadiusW])
                    ? bsm_pkg::RadiusMax : nr_full[bsm_pkg::RadiusW-1:0];
        end
      end
      bsm_pkg::ST_AX_LOAD: begin
        drem_r <= prod[bsm_pkg::ProdW-1 -: bsm_pkg::DivisorW];
        dlo_r  <= prod[bsm_pkg::DivSteps-1:0];
        q_r    <= '0;
      end
      bsm_pkg::ST_DIV: begin
        drem_r <= div_ge ? bsm_pkg::DivisorW'(div_sh - {1'b0, divisor})
                         : div_sh[bsm_pkg::DivisorW-1:0];
        dlo_r  <= {dlo_r[bsm_pkg::DivSteps-2:0], 1'b0};
        q_r    <= {q_r[bsm_pkg::DivSteps-2:0], div_ge};
      end
      bsm_pkg::ST_AX_DONE: begin
        case (axis_r)
          2'd0:    resx_r <= new_ctr;
          2'd1:    resy_r <= new_ctr;
          default: resz_r <= new_ctr;
        endcase
      end
      bsm_pkg::ST_WRITE: begin
        if (write_go) begin
          ox_r   <= resx_r;
          oy_r   <= resy_r;
          oz_r   <= resz_r;
          or_r   <= resr_r;
          osat_r <= ressat_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = ovalid_r;
  assign out_ch.out_center_x = ox_r;
  assign out_ch.out_center_y = oy_r;
  assign out_ch.out_center_z = oz_r;
  assign out_ch.out_radius   = or_r;
  assign out_ch.saturated    = osat_r;

endmodule

FILE: rtl/bsm_checker.sv
module bsm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bsm_pkg::RadiusW-1:0]   out_radius,
  input logic                          saturated
);

  // a word in the output register stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_radius))
    else $error("output word dropped or changed while stalled");

  // the block is busy in the cycle after taking a word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a word while busy");

  // a clamped radius is the largest one
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && saturated |-> out_radius == bsm_pkg::RadiusMax)
    else $error("saturated flag without clamped radius");

  // reset empties the output
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind bounding_sphere_merge_top bsm_checker u_bsm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_radius (out_ch.out_radius),
  .saturated  (out_ch.saturated)
);
